// ===== design/mcr_pkg.sv =====
`default_nettype none

package mcr_pkg;

  // Command codes of one item.
  localparam logic [2:0] CMD_READ   = 3'd0;
  localparam logic [2:0] CMD_WRITE  = 3'd1;
  localparam logic [2:0] CMD_MOTION = 3'd2;
  localparam logic [2:0] CMD_BUTTON = 3'd3;
  localparam logic [2:0] CMD_WHEEL  = 3'd4;

  // Register offsets on the bus side.
  localparam logic [3:0] OFF_X_HI    = 4'd0;
  localparam logic [3:0] OFF_X_LO    = 4'd1;
  localparam logic [3:0] OFF_Y_HI    = 4'd2;
  localparam logic [3:0] OFF_Y_LO    = 4'd3;
  localparam logic [3:0] OFF_HOT_X   = 4'd4;
  localparam logic [3:0] OFF_HOT_Y   = 4'd5;
  localparam logic [3:0] OFF_SIZE    = 4'd6;
  localparam logic [3:0] OFF_WHEEL   = 4'd7;
  localparam logic [3:0] OFF_FLAGS   = 4'd8;
  localparam logic [3:0] OFF_PAL_IDX = 4'd9;
  localparam logic [3:0] OFF_PAL_HI  = 4'd10;
  localparam logic [3:0] OFF_PAL_LO  = 4'd11;
  localparam logic [3:0] OFF_BMP_IDX = 4'd12;
  localparam logic [3:0] OFF_BMP_PIX = 4'd13;

  localparam logic [5:0] SIZE_LIMIT = 6'h20;
  localparam int unsigned NUM_BUTTONS = 6;
  localparam int unsigned NUM_COLORS  = 16;
  localparam int unsigned BMP_DEPTH   = 256;

  localparam logic [15:0] DEFAULT_COLORS [NUM_COLORS] = '{
    16'h0000, 16'h0005, 16'h000A, 16'h000F, 16'hFFFF, 16'hCCCF, 16'h555F, 16'h00CF,
    16'h0C0F, 16'hC00F, 16'h00FF, 16'h0F0F, 16'h0FFF, 16'hF0FF, 16'hFF0F, 16'hFFFF
  };

  typedef struct packed {
    logic [2:0]         cmd;
    logic [3:0]         reg_offset;
    logic [7:0]         wdata;
    logic [15:0]        pos_x;
    logic [15:0]        pos_y;
    logic [2:0]         button_number;
    logic               button_pressed;
    logic [7:0]         click_count;
    logic signed [7:0]  wheel_step;
  } item_t;

  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [7:0] data;
  } bmp_wr_t;

endpackage

`default_nettype wire

// ===== design/mcr_bitmap.sv =====
`default_nettype none

// Cursor bitmap store: one write port, one registered read port, and a valid bit
// per entry so that entries never written since reset read as zero.
module mcr_bitmap
  import mcr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire bmp_wr_t    wr,
  input  wire logic [7:0] rd_addr,
  output logic      [7:0] rd_data
);

  logic [7:0]           mem [BMP_DEPTH];
  logic [BMP_DEPTH-1:0] vld;
  logic [7:0]           rd_q;
  logic                 rd_vld_q;
  logic                 hit;

  assign hit = wr.en && (wr.addr == rd_addr);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // A write to the address being read is forwarded.
  always_ff @(posedge clk) begin
    if (hit) begin
      rd_q <= wr.data;
    end else begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr.en) begin
        vld[wr.addr] <= 1'b1;
      end
      rd_vld_q <= vld[rd_addr] | hit;
    end
  end

  assign rd_data = rd_vld_q ? rd_q : 8'h00;

endmodule

`default_nettype wire

// ===== design/mcr_core.sv =====
`default_nettype none

// Register file and command decode. State changes at the edge where exec is high.
module mcr_core
  import mcr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       exec,
  input  wire item_t      item,
  input  wire logic [7:0] bmp_rd_data,
  output bmp_wr_t         bmp_wr,
  output logic      [7:0] bmp_rd_addr,
  output logic      [7:0] rdata_next
);

  logic [15:0] cursor_x, cursor_x_next;
  logic [15:0] cursor_y, cursor_y_next;
  logic [7:0]  hotspot_x, hotspot_x_next;
  logic [7:0]  hotspot_y, hotspot_y_next;
  logic [5:0]  cursor_size, cursor_size_next;
  logic [7:0]  wheel_value, wheel_value_next;
  logic [7:0]  button_state, button_state_next;
  logic [7:0]  palette_select, palette_select_next;
  logic [7:0]  pixel_select, pixel_select_next;
  logic [15:0] color_table [NUM_COLORS];

  logic [3:0]  pal_idx;
  logic [15:0] color_word;
  logic        color_hi_we;
  logic        color_lo_we;
  logic [5:0]  size_clamped;
  logic [7:0]  press_flags;

  assign pal_idx      = palette_select[3:0];
  assign color_word   = color_table[pal_idx];
  assign size_clamped = (item.wdata >= {2'b00, SIZE_LIMIT}) ? SIZE_LIMIT : item.wdata[5:0];

  // Button numbers outside one to six select no flag bit.
  always_comb begin
    press_flags = {item.click_count[1:0], 6'b000000};
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (item.button_number == 3'(i + 1)) begin
        press_flags[i] = 1'b1;
      end
    end
  end

  always_comb begin
    cursor_x_next       = cursor_x;
    cursor_y_next       = cursor_y;
    hotspot_x_next      = hotspot_x;
    hotspot_y_next      = hotspot_y;
    cursor_size_next    = cursor_size;
    wheel_value_next    = wheel_value;
    button_state_next   = button_state;
    palette_select_next = palette_select;
    pixel_select_next   = pixel_select;
    color_hi_we         = 1'b0;
    color_lo_we         = 1'b0;
    bmp_wr              = '0;
    rdata_next          = 8'h00;

    if (exec) begin
      unique case (item.cmd)
        CMD_READ: begin
          unique case (item.reg_offset)
            OFF_X_HI:    rdata_next = cursor_x[15:8];
            OFF_X_LO:    rdata_next = cursor_x[7:0];
            OFF_Y_HI:    rdata_next = cursor_y[15:8];
            OFF_Y_LO:    rdata_next = cursor_y[7:0];
            OFF_HOT_X:   rdata_next = hotspot_x;
            OFF_HOT_Y:   rdata_next = hotspot_y;
            OFF_SIZE:    rdata_next = {2'b00, cursor_size};
            OFF_WHEEL: begin
              rdata_next       = wheel_value;
              wheel_value_next = 8'h00;
            end
            OFF_FLAGS:   rdata_next = button_state;
            OFF_PAL_IDX: rdata_next = palette_select;
            OFF_PAL_HI:  rdata_next = color_word[15:8];
            OFF_PAL_LO:  rdata_next = color_word[7:0];
            OFF_BMP_IDX: rdata_next = pixel_select;
            OFF_BMP_PIX: rdata_next = bmp_rd_data;
            default:     rdata_next = 8'h00;
          endcase
        end
        CMD_WRITE: begin
          rdata_next = item.wdata;
          unique case (item.reg_offset)
            OFF_HOT_X:   hotspot_x_next = item.wdata;
            OFF_HOT_Y:   hotspot_y_next = item.wdata;
            OFF_SIZE: begin
              cursor_size_next = size_clamped;
              rdata_next       = {2'b00, size_clamped};
            end
            OFF_WHEEL:   wheel_value_next = item.wdata;
            OFF_PAL_IDX: palette_select_next = item.wdata;
            OFF_PAL_HI:  color_hi_we = 1'b1;
            OFF_PAL_LO:  color_lo_we = 1'b1;
            OFF_BMP_IDX: pixel_select_next = item.wdata;
            OFF_BMP_PIX: begin
              bmp_wr.en   = 1'b1;
              bmp_wr.addr = pixel_select;
              bmp_wr.data = item.wdata;
            end
            // Position and flag registers are read only; unmapped offsets ignore writes.
            default: ;
          endcase
        end
        CMD_MOTION: begin
          cursor_x_next = item.pos_x;
          cursor_y_next = item.pos_y;
        end
        CMD_BUTTON: begin
          button_state_next = item.button_pressed ? press_flags : 8'h00;
        end
        CMD_WHEEL: begin
          wheel_value_next = 8'(item.wheel_step);
        end
        default: ;
      endcase
    end
  end

  // The bitmap port reads the pixel that the index will select after this edge.
  assign bmp_rd_addr = pixel_select_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x       <= '0;
      cursor_y       <= '0;
      hotspot_x      <= '0;
      hotspot_y      <= '0;
      cursor_size    <= '0;
      wheel_value    <= '0;
      button_state   <= '0;
      palette_select <= '0;
      pixel_select   <= '0;
      for (int i = 0; i < NUM_COLORS; i++) begin
        color_table[i] <= DEFAULT_COLORS[i];
      end
    end else begin
      cursor_x       <= cursor_x_next;
      cursor_y       <= cursor_y_next;
      hotspot_x      <= hotspot_x_next;
      hotspot_y      <= hotspot_y_next;
      cursor_size    <= cursor_size_next;
      wheel_value    <= wheel_value_next;
      button_state   <= button_state_next;
      palette_select <= palette_select_next;
      pixel_select   <= pixel_select_next;
      if (color_hi_we) begin
        color_table[pal_idx][15:8] <= item.wdata;
      end
      if (color_lo_we) begin
        color_table[pal_idx][7:0] <= item.wdata;
      end
    end
  end

  a_size_limit : assert property (@(posedge clk) disable iff (rst)
    cursor_size <= SIZE_LIMIT)
    else $error("cursor size above limit");

  a_wheel_clear : assert property (@(posedge clk) disable iff (rst)
    exec && item.cmd == CMD_READ && item.reg_offset == OFF_WHEEL |=> wheel_value == 8'h00)
    else $error("wheel value not cleared after read");

  a_flags_shape : assert property (@(posedge clk) disable iff (rst)
    $onehot0(button_state[5:0]))
    else $error("more than one button flag set");

endmodule

`default_nettype wire

// ===== design/mouse_cursor_register_device_unit.sv =====
`default_nettype none

// Mouse-cursor register block.
// The item channel (item_valid / item_ready) carries one beat per bus read, bus write
// or pointer event; cmd selects which, and the other fields carry its operands.
// The result channel (result_valid / result_ready) returns exactly one beat per item:
// rdata holds the byte read, the byte written (clamped for the size register), or zero
// for pointer events and unused command codes.
// An accepted beat lands in an input register; once the result register is free or
// being emptied, the register decode updates the state and the answer is loaded into
// the result register. One beat per cycle is sustained while the receiver takes every
// result, with a single decode pass and a registered read of the bitmap memory.
// Reset clears all pointer and index registers, loads the default color table and
// marks every bitmap entry as zero; the block takes items as soon as reset is released.
// When the receiver stalls, the result register holds its beat and one more item may
// wait in the input register; item_ready drops only when both are full and stalled.
module mouse_cursor_register_device_unit
  import mcr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire logic [2:0]        cmd,
  input  wire logic [3:0]        reg_offset,
  input  wire logic [7:0]        wdata,
  input  wire logic [15:0]       pos_x,
  input  wire logic [15:0]       pos_y,
  input  wire logic [2:0]        button_number,
  input  wire logic              button_pressed,
  input  wire logic [7:0]        click_count,
  input  wire logic signed [7:0] wheel_step,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output logic      [7:0]        rdata
);

  item_t      item_q;
  logic       item_vld;
  logic       exec;
  logic [7:0] rdata_next;
  bmp_wr_t    bmp_wr;
  logic [7:0] bmp_rd_addr;
  logic [7:0] bmp_rd_data;

  // The held item executes whenever the result register is free or being emptied.
  assign exec       = item_vld && (!result_valid || result_ready);
  assign item_ready = !item_vld || exec;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
    end else if (item_ready) begin
      item_vld <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      item_q.cmd            <= cmd;
      item_q.reg_offset     <= reg_offset;
      item_q.wdata          <= wdata;
      item_q.pos_x          <= pos_x;
      item_q.pos_y          <= pos_y;
      item_q.button_number  <= button_number;
      item_q.button_pressed <= button_pressed;
      item_q.click_count    <= click_count;
      item_q.wheel_step     <= wheel_step;
    end
  end

  mcr_core u_core (
    .clk         (clk),
    .rst         (rst),
    .exec        (exec),
    .item        (item_q),
    .bmp_rd_data (bmp_rd_data),
    .bmp_wr      (bmp_wr),
    .bmp_rd_addr (bmp_rd_addr),
    .rdata_next  (rdata_next)
  );

  mcr_bitmap u_bitmap (
    .clk     (clk),
    .rst     (rst),
    .wr      (bmp_wr),
    .rd_addr (bmp_rd_addr),
    .rd_data (bmp_rd_data)
  );

  // Result register: loaded when the held item executes, emptied when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (exec) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      rdata <= rdata_next;
    end
  end

  a_exec_loads : assert property (@(posedge clk) disable iff (rst)
    exec |=> result_valid)
    else $error("executed item produced no result");

  a_item_kept : assert property (@(posedge clk) disable iff (rst)
    item_vld && !exec |=> item_vld && $stable(item_q))
    else $error("waiting item lost or changed");

  a_event_zero : assert property (@(posedge clk) disable iff (rst)
    exec && (item_q.cmd == CMD_MOTION || item_q.cmd == CMD_BUTTON ||
             item_q.cmd == CMD_WHEEL) |=> rdata == 8'h00)
    else $error("pointer event returned nonzero data");

endmodule

`default_nettype wire
